>>> rtl/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg
// Shared types and constants for the run-length text encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rte_pkg;

  localparam logic [32:0] MAX_RUN = 33'd65535;

  // run limit clamped to what a 16-bit count can hold
  localparam logic [15:0] RUN_LIMIT =
    (MAX_RUN > 33'd65535) ? 16'hFFFF :
    (MAX_RUN < 33'd1)     ? 16'd1    : MAX_RUN[15:0];

  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  localparam int          MAX_DIGITS  = 5;
  localparam int          DIGIT_IDX_W = $clog2(MAX_DIGITS + 1);

  // floor(v / 10) = (v * 52429) >> 19 for any 16-bit v
  localparam logic [31:0] DIV10_MUL   = 32'd52429;
  localparam int          DIV10_SHIFT = 19;

  localparam int          QUEUE_DEPTH = 4;
  localparam int          QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int          QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       last_of_group;
    logic       end_of_text;
  } out_item_t;

  // one run to be written out by the back end
  typedef struct packed {
    logic [15:0] run_length;
    logic [7:0]  run_char;
    logic        eot;
    logic        last;
  } run_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_EMIT
  } back_state_t;

endpackage

`default_nettype wire

>>> rtl/rle_text_encoder.sv
// ----------------------------------------------------------------------------
// rle_text_encoder
// Run-length encoder for a text stream with decimal run counts.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_item carries one character per
// transaction, with is_final on the last character of the text. Output
// channel out_valid/out_ready/out_item carries one encoded byte per
// transaction: the run length as decimal digits, then the run character.
// last_of_group marks the last byte caused by one input, end_of_text the
// last byte of the text.
// A character that only extends a run is accepted without touching the
// queue. A run boundary queues a run; the digit emitter fetches it from
// the queue, converts one decimal digit per cycle (one divide-by-ten
// multiply), then writes one output byte per cycle while the receiver is
// ready. A four-entry queue lets input continue while runs are written
// out; the front stalls when the queue is full, and after a final
// character that closes a run, while the second run is queued.
// Reset clears the open run, the queue and the output valid flag.
// When the receiver stalls, the output byte holds and the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_text_encoder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rte_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rte_pkg::out_item_t      out_item
);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  rte_pkg::run_cmd_t q_cmd;
  rte_pkg::run_cmd_t q_head;

  rte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  rte_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  rte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("push into full run queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("pop from empty run queue");

  a_eot_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.end_of_text |-> out_item.last_of_group)
    else $error("end of text without end of group");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !q_push)
    else $error("activity right after reset");
`endif

endmodule

`default_nettype wire

>>> rtl/rte_queue.sv
// ----------------------------------------------------------------------------
// rte_queue
// Small command queue between the run tracker and the digit emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rte_pkg::run_cmd_t push_cmd,
  input  wire logic              pop,
  output rte_pkg::run_cmd_t      head,
  output logic                   full,
  output logic                   empty
);

  rte_pkg::run_cmd_t                    entries [rte_pkg::QUEUE_DEPTH];
  logic [rte_pkg::QUEUE_PTR_W-1:0]      wr_ptr;
  logic [rte_pkg::QUEUE_PTR_W-1:0]      rd_ptr;
  logic [rte_pkg::QUEUE_CNT_W-1:0]      count;

  assign full  = (count == rte_pkg::QUEUE_CNT_W'(rte_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/rte_front.sv
// ----------------------------------------------------------------------------
// rte_front
// Accepts characters, tracks the open run and queues runs to be written out.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rte_pkg::in_item_t in_item,
  input  wire logic              q_full,
  output logic                   q_push,
  output rte_pkg::run_cmd_t      q_cmd
);

  logic [7:0]        run_char;
  logic [15:0]       run_length;
  logic              run_open;
  logic              pend_valid;
  rte_pkg::run_cmd_t pend_cmd;

  logic              accept;
  logic              extend;
  logic              flush;
  logic [15:0]       new_length;
  logic [7:0]        new_char;
  rte_pkg::run_cmd_t flush_cmd;
  rte_pkg::run_cmd_t final_cmd;

  assign in_ready = !pend_valid && !q_full;
  assign accept   = in_valid && in_ready;

  assign extend = run_open && (in_item.in_char == run_char) &&
                  (run_length < rte_pkg::RUN_LIMIT);
  assign flush  = run_open && !extend;

  assign new_length = extend ? 16'(run_length + 16'd1) : 16'd1;
  assign new_char   = extend ? run_char : in_item.in_char;

  always_comb begin
    flush_cmd.run_length = run_length;
    flush_cmd.run_char   = run_char;
    flush_cmd.eot        = 1'b0;
    flush_cmd.last       = !in_item.is_final;
    final_cmd.run_length = new_length;
    final_cmd.run_char   = new_char;
    final_cmd.eot        = 1'b1;
    final_cmd.last       = 1'b1;
  end

  always_comb begin
    q_push = 1'b0;
    q_cmd  = flush_cmd;
    if (pend_valid) begin
      q_push = !q_full;
      q_cmd  = pend_cmd;
    end else if (accept && flush) begin
      q_push = 1'b1;
      q_cmd  = flush_cmd;
    end else if (accept && in_item.is_final) begin
      q_push = 1'b1;
      q_cmd  = final_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && flush && in_item.is_final) begin
      pend_cmd <= final_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_char   <= '0;
      run_length <= '0;
      run_open   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && !q_full) begin
        pend_valid <= 1'b0;
      end else if (accept && flush && in_item.is_final) begin
        pend_valid <= 1'b1;
      end
      if (accept) begin
        if (in_item.is_final) begin
          run_char   <= '0;
          run_length <= '0;
          run_open   <= 1'b0;
        end else begin
          run_char   <= new_char;
          run_length <= new_length;
          run_open   <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/rte_back.sv
// ----------------------------------------------------------------------------
// rte_back
// Turns queued runs into decimal digits followed by the run character.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rte_pkg::run_cmd_t q_head,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rte_pkg::out_item_t     out_item
);

  rte_pkg::back_state_t            state;
  rte_pkg::back_state_t            state_next;
  rte_pkg::run_cmd_t               cmd;
  logic [15:0]                     value;
  logic [3:0]                      digits [rte_pkg::MAX_DIGITS];
  logic [rte_pkg::DIGIT_IDX_W-1:0] nd;
  logic [rte_pkg::DIGIT_IDX_W-1:0] pos;

  logic [31:0]                     prod;
  logic [15:0]                     quo;
  logic [15:0]                     rem;
  logic                            slot_free;
  logic                            emit;
  rte_pkg::out_item_t              emit_item;

  // one decimal digit per cycle
  assign prod = 32'(value) * rte_pkg::DIV10_MUL;
  assign quo  = 16'(prod >> rte_pkg::DIV10_SHIFT);
  assign rem  = value - 16'((quo << 3) + (quo << 1));

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      rte_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_next = rte_pkg::BK_CONV;
        end
      end
      rte_pkg::BK_CONV: begin
        if (quo == '0) begin
          state_next = rte_pkg::BK_EMIT;
        end
      end
      rte_pkg::BK_EMIT: begin
        if (slot_free && pos == '0) begin
          state_next = rte_pkg::BK_IDLE;
        end
      end
      default: state_next = rte_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == rte_pkg::BK_IDLE) && !q_empty;
    emit  = (state == rte_pkg::BK_EMIT) && slot_free;
    if (pos != '0) begin
      emit_item.out_symbol    = rte_pkg::ASCII_ZERO + 8'(digits[pos - 1'b1]);
      emit_item.last_of_group = 1'b0;
      emit_item.end_of_text   = 1'b0;
    end else begin
      emit_item.out_symbol    = cmd.run_char;
      emit_item.last_of_group = cmd.last;
      emit_item.end_of_text   = cmd.eot;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd   <= q_head;
      value <= (q_head.run_length == '0) ? 16'd1 : q_head.run_length;
      nd    <= '0;
    end
    if (state == rte_pkg::BK_CONV) begin
      digits[nd] <= rem[3:0];
      nd         <= nd + 1'b1;
      value      <= quo;
      pos        <= nd + 1'b1;
    end
    if (emit) begin
      out_item <= emit_item;
      pos      <= pos - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rte_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for rle_text_encoder: directed texts, a run with a
// three-digit count, random texts under sender and receiver idling, and a long
// receiver hold-off. A predictor works out the encoded bytes of every accepted
// character and a monitor compares every output transaction with them in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] RUN_CAP     = rte_pkg::RUN_LIMIT;
  localparam logic [7:0]  DIGIT_ZERO  = "0";
  localparam int          RESET_LEN   = 9;
  localparam int          DRAIN_TAIL  = 24;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          PHASE_ITEMS = 56;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  rte_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  rte_pkg::out_item_t out_item;

  // predictor state
  logic [7:0]         cur_char = '0;
  logic [15:0]        cur_len = '0;
  logic               cur_open = 1'b0;
  rte_pkg::out_item_t group_bytes[$];
  rte_pkg::out_item_t expected_bytes[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int chars_sent = 0;
  int texts_sent = 0;
  int bytes_checked = 0;

  rle_text_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[rle_text_encoder] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // decimal digits of the run length, then the run character
  function automatic void add_run(input logic [15:0] len, input logic [7:0] ch,
                                  input logic eot);
    logic [7:0]         digs[$];
    int unsigned        v;
    rte_pkg::out_item_t b;
    v = len;
    do begin
      digs.push_front(DIGIT_ZERO + 8'(v % 10));
      v /= 10;
    end while (v != 0);
    b = '0;
    foreach (digs[i]) begin
      b.out_symbol = digs[i];
      group_bytes.push_back(b);
    end
    b.out_symbol = ch;
    b.end_of_text = eot;
    group_bytes.push_back(b);
  endfunction

  function automatic void encode_char(input rte_pkg::in_item_t it);
    group_bytes.delete();
    if (cur_open && it.in_char == cur_char && cur_len < RUN_CAP) begin
      cur_len++;
    end else begin
      if (cur_open) add_run(cur_len, cur_char, 1'b0);
      cur_char = it.in_char;
      cur_len = 16'd1;
      cur_open = 1'b1;
    end
    if (it.is_final) begin
      add_run(cur_len, cur_char, 1'b1);
      cur_open = 1'b0;
      cur_len = '0;
      cur_char = '0;
      texts_sent++;
    end
    if (group_bytes.size() > 0) group_bytes[group_bytes.size() - 1].last_of_group = 1'b1;
    foreach (group_bytes[i]) expected_bytes.push_back(group_bytes[i]);
  endfunction

  // output monitor
  always @(posedge clk) begin
    rte_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected transaction, out_symbol %h", out_item.out_symbol);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (out_item.out_symbol !== want.out_symbol) begin
          $error("out_symbol expected %h got %h", want.out_symbol, out_item.out_symbol);
          mismatch_count++;
        end
        if (out_item.last_of_group !== want.last_of_group) begin
          $error("last_of_group expected %b got %b", want.last_of_group,
                 out_item.last_of_group);
          mismatch_count++;
        end
        if (out_item.end_of_text !== want.end_of_text) begin
          $error("end_of_text expected %b got %b", want.end_of_text, out_item.end_of_text);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic fin);
    rte_pkg::in_item_t it;
    it.in_char = c;
    it.is_final = fin;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    encode_char(it);
    chars_sent++;
  endtask

  task automatic send_run(input logic [7:0] c, input int n, input logic close);
    for (int i = 0; i < n; i++) send_char(c, close && (i == n - 1));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(1)) return "a" + 8'($urandom_range(2));
    return 8'($urandom_range(255));
  endfunction

  task automatic random_text();
    int runs;
    int len;
    int r;
    if ($urandom_range(99) < 20) begin
      // noise: unrelated bytes
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) send_char(8'($urandom_range(255)), i == len - 1);
    end else begin
      runs = $urandom_range(1, 6);
      for (int k = 0; k < runs; k++) begin
        r = $urandom_range(99);
        if (r < 60) len = $urandom_range(1, 3);
        else if (r < 90) len = $urandom_range(4, 12);
        else if (r < 97) len = $urandom_range(13, 40);
        else len = $urandom_range(90, 120);
        send_run(pick_char(), len, k == runs - 1);
      end
    end
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_run("a", 2, 1'b0);
    send_char("b", 1'b1);
    send_run("c", 10, 1'b0);
    send_char("d", 1'b1);
    send_run("e", 2, 1'b1);
    send_char(8'h55, 1'b0);
    send_char(8'hAA, 1'b1);
    wait_drained();
  endtask

  task automatic test_long_run();
    idle_pct = 0;
    stall_pct = 0;
    // three-digit count closed by another character
    send_run("m", 100, 1'b0);
    send_char("n", 1'b1);
    wait_drained();
  endtask

  task automatic run_phase(input int idle, input int stall);
    int start;
    idle_pct = idle;
    stall_pct = stall;
    start = chars_sent;
    while (chars_sent - start < PHASE_ITEMS) random_text();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0);
    run_phase(71, 0);
    run_phase(0, 71);
    run_phase(29, 29);
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 300;
    for (int i = 0; i < 40; i++) send_char(i[0] ? "q" : "p", i == 39);
    wait_drained();
  endtask

  initial begin
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_long_run();
    test_random_traffic();
    test_backpressure();
    if (expected_bytes.size() != 0) begin
      $error("%0d encoded bytes never arrived", expected_bytes.size());
      mismatch_count++;
    end
    $display("encoded %0d texts from %0d characters, %0d output bytes checked",
             texts_sent, chars_sent, bytes_checked);
    $display("short and three-digit runs, random idling and a long receiver hold-off");
    if (mismatch_count == 0) begin
      $display("[rle_text_encoder] OK");
    end else begin
      $display("[rle_text_encoder] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rte_pkg.sv
rtl/rte_queue.sv
rtl/rte_front.sv
rtl/rte_back.sv
rtl/rle_text_encoder.sv
test/tb.sv
